>>> hw/rtl/srcuv_pkg.sv
// ---------------------------------------------------------------------------
// srcuv_pkg
// Shared constants, types and helper functions for the sprite clipper.
// ---------------------------------------------------------------------------
package srcuv_pkg;

    // Fixed-point formats.
    localparam int POS_FRAC   = 4;
    localparam int UV_FRAC    = 16;
    localparam int POS_W      = 21;
    localparam int FB_W       = 15;
    localparam int OPOS_W     = 19;
    localparam int UV_W       = 17;
    localparam int CALC_W     = POS_W + 2;
    localparam int PROD_W     = POS_W + UV_W;
    localparam int NUM_LANES  = 4;
    localparam int FIFO_DEPTH = 4;

    // Derived constants.
    localparam logic signed [CALC_W-1:0] HALF     = CALC_W'(1) <<< (POS_FRAC - 1);
    localparam logic signed [CALC_W-1:0] MAX_SIZE = CALC_W'(65536) <<< POS_FRAC;
    localparam logic [UV_W:0]            UV_ONE   = (UV_W + 1)'(1) << UV_FRAC;
    localparam logic [FB_W-1:0]          FB_WIDTH_RESET  = FB_W'(640);
    localparam logic [FB_W-1:0]          FB_HEIGHT_RESET = FB_W'(480);

    // Configuration register indexes.
    typedef enum logic [0:0] {
        REG_FB_WIDTH  = 1'b0,
        REG_FB_HEIGHT = 1'b1
    } reg_index_t;

    // Per-item data that rides along with the divisions.
    typedef struct packed {
        logic                    visible;
        logic [OPOS_W-1:0]       clip_x;
        logic [OPOS_W-1:0]       clip_y;
        logic [OPOS_W-1:0]       clip_w;
        logic [OPOS_W-1:0]       clip_h;
        logic [UV_W-1:0]         base_u;
        logic signed [UV_W:0]    base_v;
    } side_t;

    // Classified request as held in the queue.
    typedef struct packed {
        side_t                             side;
        logic [NUM_LANES-1:0][POS_W-1:0]   offs;
        logic [UV_W-1:0]                   span_u;
        logic [UV_W-1:0]                   span_v;
        logic [POS_W-1:0]                  size_w;
        logic [POS_W-1:0]                  size_h;
    } front_t;

    // Final result as registered at the output.
    typedef struct packed {
        logic              visible;
        logic [OPOS_W-1:0] clip_x;
        logic [OPOS_W-1:0] clip_y;
        logic [OPOS_W-1:0] clip_w;
        logic [OPOS_W-1:0] clip_h;
        logic [UV_W-1:0]   tex_u_start;
        logic [UV_W-1:0]   tex_u_end;
        logic [UV_W-1:0]   tex_v_start;
        logic [UV_W-1:0]   tex_v_end;
    } res_t;

    // Clamp a signed value into [0, hi].
    function automatic logic signed [CALC_W-1:0] clamp_pos(
        input logic signed [CALC_W-1:0] v,
        input logic signed [CALC_W-1:0] hi
    );
        logic signed [CALC_W-1:0] r;
        if (v < 0)
        begin
            r = '0;
        end
        else if (v > hi)
        begin
            r = hi;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    // Saturate a texture coordinate into the output field.
    function automatic logic [UV_W-1:0] sat_uv(input logic signed [UV_W+1:0] v);
        logic [UV_W-1:0] r;
        if (v < 0)
        begin
            r = '0;
        end
        else if (v[UV_W])
        begin
            r = '1;
        end
        else
        begin
            r = v[UV_W-1:0];
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/srcuv_if.sv
// ---------------------------------------------------------------------------
// srcuv interfaces
// Valid/ready channels for sprite requests, results and register writes.
// ---------------------------------------------------------------------------
interface srcuv_in_if;
    logic                             valid;
    logic                             ready;
    logic signed [srcuv_pkg::POS_W-1:0] pos_x;
    logic signed [srcuv_pkg::POS_W-1:0] pos_y;
    logic [srcuv_pkg::POS_W-1:0]      size_w;
    logic [srcuv_pkg::POS_W-1:0]      size_h;
    logic [srcuv_pkg::UV_W-1:0]       u_low;
    logic [srcuv_pkg::UV_W-1:0]       u_high;
    logic [srcuv_pkg::UV_W-1:0]       v_low;
    logic [srcuv_pkg::UV_W-1:0]       v_high;

    modport source (output valid, pos_x, pos_y, size_w, size_h, u_low, u_high,
                    v_low, v_high, input ready);
    modport sink   (input valid, pos_x, pos_y, size_w, size_h, u_low, u_high,
                    v_low, v_high, output ready);
endinterface

interface srcuv_out_if;
    logic                          valid;
    logic                          ready;
    logic                          visible;
    logic [srcuv_pkg::OPOS_W-1:0]  clip_x;
    logic [srcuv_pkg::OPOS_W-1:0]  clip_y;
    logic [srcuv_pkg::OPOS_W-1:0]  clip_w;
    logic [srcuv_pkg::OPOS_W-1:0]  clip_h;
    logic [srcuv_pkg::UV_W-1:0]    tex_u_start;
    logic [srcuv_pkg::UV_W-1:0]    tex_u_end;
    logic [srcuv_pkg::UV_W-1:0]    tex_v_start;
    logic [srcuv_pkg::UV_W-1:0]    tex_v_end;

    modport source (output valid, visible, clip_x, clip_y, clip_w, clip_h,
                    tex_u_start, tex_u_end, tex_v_start, tex_v_end, input ready);
    modport sink   (input valid, visible, clip_x, clip_y, clip_w, clip_h,
                    tex_u_start, tex_u_end, tex_v_start, tex_v_end, output ready);
endinterface

interface srcuv_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [0:0]                  index;
    logic [srcuv_pkg::FB_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/srcuv_front.sv
// ---------------------------------------------------------------------------
// srcuv_front
// Holds the framebuffer size, clips each request and classifies it.
// ---------------------------------------------------------------------------
module srcuv_front
(
    input  logic                clk,
    input  logic                rst_n,
    srcuv_cfg_if.sink           cfg,
    srcuv_in_if.sink            sprite,
    input  logic                q_full,
    output logic                q_push,
    output srcuv_pkg::front_t   q_data
);

    localparam int CW = srcuv_pkg::CALC_W;
    localparam int PW = srcuv_pkg::POS_W;
    localparam int PF = srcuv_pkg::POS_FRAC;
    localparam int FW = srcuv_pkg::FB_W;
    localparam int UW = srcuv_pkg::UV_W;

    logic [FW-1:0] fb_width_reg;
    logic [FW-1:0] fb_height_reg;

    logic signed [CW-1:0] left, top, w, h, right, bottom, fbw, fbh;
    logic signed [CW-1:0] cl, ct, cr, cb, cw, ch;
    logic signed [CW-1:0] d0, d1, d2, d3;
    logic                 reject;

    // Register writes are always taken.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fb_width_reg  <= srcuv_pkg::FB_WIDTH_RESET;
            fb_height_reg <= srcuv_pkg::FB_HEIGHT_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                srcuv_pkg::REG_FB_WIDTH:  fb_width_reg  <= cfg.data;
                srcuv_pkg::REG_FB_HEIGHT: fb_height_reg <= cfg.data;
                default:                  fb_width_reg  <= fb_width_reg;
            endcase
        end
    end

    // Extend everything into one signed working width.
    assign left = CW'(sprite.pos_x);
    assign top  = CW'(sprite.pos_y);
    assign w    = signed'({2'b00, sprite.size_w});
    assign h    = signed'({2'b00, sprite.size_h});
    assign fbw  = signed'({{(CW-FW-PF){1'b0}}, fb_width_reg, {PF{1'b0}}});
    assign fbh  = signed'({{(CW-FW-PF){1'b0}}, fb_height_reg, {PF{1'b0}}});

    // Edges, clamped edges and clipped extents.
    assign right  = left + w;
    assign bottom = top + h;
    assign cl = srcuv_pkg::clamp_pos(left, fbw);
    assign ct = srcuv_pkg::clamp_pos(top, fbh);
    assign cr = srcuv_pkg::clamp_pos(right, fbw);
    assign cb = srcuv_pkg::clamp_pos(bottom, fbh);
    assign cw = cr - cl;
    assign ch = cb - ct;

    // Distances from the unclipped edges.
    assign d0 = cl - left;
    assign d1 = cr - left;
    assign d2 = ct - top;
    assign d3 = cb - top;

    // Rejection covers empty framebuffer, bad size, empty span, fully outside
    // and thin clip.
    always_comb
    begin
        reject = (fb_width_reg == '0) || (fb_height_reg == '0)
              || (w < srcuv_pkg::HALF) || (h < srcuv_pkg::HALF)
              || (w > srcuv_pkg::MAX_SIZE) || (h > srcuv_pkg::MAX_SIZE)
              || (sprite.u_high <= sprite.u_low) || (sprite.v_high <= sprite.v_low)
              || (right <= 0) || (bottom <= 0) || (left >= fbw) || (top >= fbh)
              || (cw < srcuv_pkg::HALF) || (ch < srcuv_pkg::HALF);
    end

    // Build the queue entry.
    always_comb
    begin
        q_data.side.visible = !reject;
        q_data.side.clip_x  = cl[srcuv_pkg::OPOS_W-1:0];
        q_data.side.clip_y  = ct[srcuv_pkg::OPOS_W-1:0];
        q_data.side.clip_w  = cw[srcuv_pkg::OPOS_W-1:0];
        q_data.side.clip_h  = ch[srcuv_pkg::OPOS_W-1:0];
        q_data.side.base_u  = sprite.u_low;
        q_data.side.base_v  = signed'(srcuv_pkg::UV_ONE - {1'b0, sprite.v_high});
        q_data.offs[0]      = d0[PW-1:0];
        q_data.offs[1]      = d1[PW-1:0];
        q_data.offs[2]      = d2[PW-1:0];
        q_data.offs[3]      = d3[PW-1:0];
        q_data.span_u       = UW'(sprite.u_high - sprite.u_low);
        q_data.span_v       = UW'(sprite.v_high - sprite.v_low);
        q_data.size_w       = sprite.size_w;
        q_data.size_h       = sprite.size_h;
    end

    assign sprite.ready = !q_full;
    assign q_push       = sprite.valid && !q_full;

endmodule

>>> hw/rtl/srcuv_fifo.sv
// ---------------------------------------------------------------------------
// srcuv_fifo
// Short queue of classified requests between the front and back ends.
// ---------------------------------------------------------------------------
module srcuv_fifo
#(
    parameter int DEPTH = srcuv_pkg::FIFO_DEPTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  srcuv_pkg::front_t   wdata,
    output logic                full,
    input  logic                pop,
    output logic                empty,
    output srcuv_pkg::front_t   rdata
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    srcuv_pkg::front_t mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = mem[rd_ptr_reg];

    // Storage is written at the tail.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> hw/rtl/srcuv_back.sv
// ---------------------------------------------------------------------------
// srcuv_back
// Multiplies, divides bit by bit in a pipeline and saturates the texture
// coordinates, then holds the result in an output register.
// ---------------------------------------------------------------------------
module srcuv_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  srcuv_pkg::front_t   q_data,
    output logic                q_pop,
    srcuv_out_if.source         result
);

    localparam int PW = srcuv_pkg::POS_W;
    localparam int UW = srcuv_pkg::UV_W;
    localparam int NL = srcuv_pkg::NUM_LANES;
    localparam int NSTEP = UW;

    logic                 en;
    logic [NSTEP:0]       vld_reg;
    srcuv_pkg::side_t     side_reg [NSTEP+1];
    logic [PW-1:0]        rem_reg  [NSTEP+1][NL];
    logic [UW-1:0]        low_reg  [NSTEP+1][NL];
    logic [UW-1:0]        q_reg    [NSTEP+1][NL];
    logic [PW-1:0]        dv_reg   [NSTEP+1][NL];
    logic                 out_valid_reg;
    srcuv_pkg::res_t      out_reg;
    srcuv_pkg::res_t      res_next;

    // The whole pipeline moves unless the output holds an untaken result.
    assign en    = !out_valid_reg || result.ready;
    assign q_pop = en && !q_empty;

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[NSTEP-1:0], q_pop};
            out_valid_reg <= vld_reg[NSTEP];
        end
    end

    // Entry stage: one product per lane.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= q_data.side;
            for (int l = 0; l < NL; l++)
            begin
                logic [srcuv_pkg::PROD_W-1:0] prod;
                prod = q_data.offs[l] * ((l < 2) ? q_data.span_u : q_data.span_v);
                rem_reg[0][l] <= prod[srcuv_pkg::PROD_W-1:UW];
                low_reg[0][l] <= prod[UW-1:0];
                q_reg[0][l]   <= '0;
                dv_reg[0][l]  <= (l < 2) ? q_data.size_w : q_data.size_h;
            end
        end
    end

    // One quotient bit per stage, most significant first.
    for (genvar k = 0; k < NSTEP; k++)
    begin : g_step
        for (genvar l = 0; l < NL; l++)
        begin : g_lane
            logic [PW:0]   trial;
            logic [PW:0]   diff;
            logic          ge;
            logic [UW-1:0] q_next;

            assign trial = {rem_reg[k][l], low_reg[k][l][UW-1-k]};
            assign diff  = trial - {1'b0, dv_reg[k][l]};
            assign ge    = (trial >= {1'b0, dv_reg[k][l]});

            always_comb
            begin
                q_next = q_reg[k][l];
                q_next[UW-1-k] = ge;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k+1][l] <= ge ? diff[PW-1:0] : trial[PW-1:0];
                    low_reg[k+1][l] <= low_reg[k][l];
                    q_reg[k+1][l]   <= q_next;
                    dv_reg[k+1][l]  <= dv_reg[k][l];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    // Add the bases, saturate and zero a rejected result.
    always_comb
    begin
        logic signed [UW+1:0] bu, bv;
        srcuv_pkg::side_t     s;
        s  = side_reg[NSTEP];
        bu = signed'({2'b00, s.base_u});
        bv = (UW + 2)'(s.base_v);
        res_next             = '0;
        if (s.visible)
        begin
            res_next.visible     = 1'b1;
            res_next.clip_x      = s.clip_x;
            res_next.clip_y      = s.clip_y;
            res_next.clip_w      = s.clip_w;
            res_next.clip_h      = s.clip_h;
            res_next.tex_u_start = srcuv_pkg::sat_uv(bu + signed'({2'b00, q_reg[NSTEP][0]}));
            res_next.tex_u_end   = srcuv_pkg::sat_uv(bu + signed'({2'b00, q_reg[NSTEP][1]}));
            res_next.tex_v_start = srcuv_pkg::sat_uv(bv + signed'({2'b00, q_reg[NSTEP][2]}));
            res_next.tex_v_end   = srcuv_pkg::sat_uv(bv + signed'({2'b00, q_reg[NSTEP][3]}));
        end
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= res_next;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.visible     = out_reg.visible;
    assign result.clip_x      = out_reg.clip_x;
    assign result.clip_y      = out_reg.clip_y;
    assign result.clip_w      = out_reg.clip_w;
    assign result.clip_h      = out_reg.clip_h;
    assign result.tex_u_start = out_reg.tex_u_start;
    assign result.tex_u_end   = out_reg.tex_u_end;
    assign result.tex_v_start = out_reg.tex_v_start;
    assign result.tex_v_end   = out_reg.tex_v_end;

endmodule

>>> hw/rtl/sprite_rect_clip_uv_top.sv
// ---------------------------------------------------------------------------
// sprite_rect_clip_uv_top
// Sprite rectangle clipper with texture coordinate rescale.
// ---------------------------------------------------------------------------
// The block takes one sprite request per clock while the queue is not full
// and returns one result per request, in order. A request is clipped against
// the framebuffer size held in the two configuration registers, classified
// and placed in a short queue in the cycle it is accepted. The back end then
// forms four products and runs four 17-stage restoring dividers, one quotient
// bit per stage; while the output is not stalled it sustains one request per
// cycle. A stalled output only stops the back end, and the queue keeps the
// front accepting until it fills.
module sprite_rect_clip_uv_top
#(
    parameter int FIFO_DEPTH = srcuv_pkg::FIFO_DEPTH
)
(
    input  logic         clk,
    input  logic         rst_n,
    srcuv_cfg_if.sink    cfg,
    srcuv_in_if.sink     sprite,
    srcuv_out_if.source  result
);

    logic              q_full, q_push, q_empty, q_pop;
    srcuv_pkg::front_t q_wdata, q_rdata;

    // Clip and classify.
    srcuv_front u_front
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .sprite (sprite),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (q_wdata)
    );

    // Queue between the two ends.
    srcuv_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .empty (q_empty),
        .rdata (q_rdata)
    );

    // Rescale texture coordinates.
    srcuv_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_data  (q_rdata),
        .q_pop   (q_pop),
        .result  (result)
    );

endmodule

>>> hw/rtl/srcuv_checker.sv
// ---------------------------------------------------------------------------
// srcuv_checker
// Port-level checks on the result channel of the sprite clipper.
// ---------------------------------------------------------------------------
module srcuv_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic                          visible,
    input logic [srcuv_pkg::OPOS_W-1:0]  clip_x,
    input logic [srcuv_pkg::OPOS_W-1:0]  clip_y,
    input logic [srcuv_pkg::OPOS_W-1:0]  clip_w,
    input logic [srcuv_pkg::OPOS_W-1:0]  clip_h,
    input logic [srcuv_pkg::UV_W-1:0]    tex_u_start,
    input logic [srcuv_pkg::UV_W-1:0]    tex_u_end,
    input logic [srcuv_pkg::UV_W-1:0]    tex_v_start,
    input logic [srcuv_pkg::UV_W-1:0]    tex_v_end
);

    localparam logic [srcuv_pkg::OPOS_W-1:0] HALF_PIX =
        srcuv_pkg::OPOS_W'(1) << (srcuv_pkg::POS_FRAC - 1);

    // A stalled result stays presented.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // A rejected result carries only zeros.
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !visible |-> (clip_x == '0) && (clip_y == '0) && (clip_w == '0)
            && (clip_h == '0) && (tex_u_start == '0) && (tex_u_end == '0)
            && (tex_v_start == '0) && (tex_v_end == '0))
        else $error("rejected result has nonzero fields");

    // A visible result is at least half a pixel in each direction.
    a_min_extent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && visible |-> (clip_w >= HALF_PIX) && (clip_h >= HALF_PIX))
        else $error("visible result thinner than half a pixel");

    // Texture coordinates grow from the start edge to the end edge.
    a_tex_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && visible |-> (tex_u_start <= tex_u_end) && (tex_v_start <= tex_v_end))
        else $error("texture coordinates out of order");

endmodule

bind sprite_rect_clip_uv_top srcuv_checker u_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .visible     (result.visible),
    .clip_x      (result.clip_x),
    .clip_y      (result.clip_y),
    .clip_w      (result.clip_w),
    .clip_h      (result.clip_h),
    .tex_u_start (result.tex_u_start),
    .tex_u_end   (result.tex_u_end),
    .tex_v_start (result.tex_v_start),
    .tex_v_end   (result.tex_v_end)
);
